// File: src/npcm_pkg.sv
// ----------------------------------------------------------------------------
// npcm_pkg
// Shared types and constants for the nearest palette color match block: the
// fixed palette, the Q16 score limit and the candidate word between stages.
// ----------------------------------------------------------------------------
`default_nettype none

package npcm_pkg;

   localparam int PAL_MAX     = 16;
   localparam int COLOR_W     = 24;
   localparam int CHAN_W      = 8;
   localparam int INDEX_W     = 4;
   localparam int TERM_W      = 25;
   localparam int SCORE_W     = 26;
   localparam int KEY_W       = 23;
   localparam int Q16_ONE     = 65536;
   localparam int SCORE_LIMIT = 100 * Q16_ONE;

   typedef logic [COLOR_W-1:0] color_type;
   typedef logic [CHAN_W-1:0]  chan_type;
   typedef logic [INDEX_W-1:0] index_type;
   typedef logic [TERM_W-1:0]  term_type;
   typedef logic [SCORE_W-1:0] score_type;
   typedef logic [KEY_W-1:0]   key_type;

   typedef struct packed {
      logic    valid;
      key_type key;
   } cand_type;

   localparam chan_type  WINDOW_RESET = 8'd25;

   localparam color_type PAL_COLORS [PAL_MAX] = '{
      24'h000000, 24'hFFFFFF, 24'h1818B4, 24'hD8E64C,
      24'hCA29BC, 24'h36E442, 24'hC82A32, 24'h26E1D2,
      24'h025ACA, 24'h80ACDE, 24'h9494DC, 24'hECF4A5,
      24'hE49AE0, 24'h9AF2A0, 24'hE4929C, 24'h9AF8EF
   };

endpackage

`default_nettype wire

// File: src/npcm_score.sv
// ----------------------------------------------------------------------------
// npcm_score
// Scores one color against every palette entry in parallel and registers one
// candidate word per entry. An exact match gets key zero.
// ----------------------------------------------------------------------------
`default_nettype none

module npcm_score #(
   parameter int PALETTE_ENTRIES = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire npcm_pkg::color_type in_color,
   input  wire npcm_pkg::chan_type  window,
   output logic                     out_valid_ff,
   output npcm_pkg::cand_type       cand_ff [PALETTE_ENTRIES]
);
   import npcm_pkg::*;

   cand_type cand_in [PALETTE_ENTRIES];

   for (genvar i = 0; i < PALETTE_ENTRIES; i++) begin : g_entry
      term_type  term [3];
      logic [2:0] chan_ok;
      score_type score;
      logic      exact;
      logic      qualified;

      for (genvar c = 0; c < 3; c++) begin : g_chan
         localparam int CH_V      = int'(PAL_COLORS[i][CHAN_W*c +: CHAN_W]);
         localparam int RECIP_INT = (CH_V == 0) ? 0 : (Q16_ONE + CH_V / 2) / CH_V;
         localparam term_type RECIP = TERM_W'(RECIP_INT);
         localparam chan_type TGT   = CHAN_W'(CH_V);

         chan_type src;
         chan_type diff;

         assign src  = in_color[CHAN_W*c +: CHAN_W];
         assign diff = (src > TGT) ? (src - TGT) : (TGT - src);
         assign chan_ok[c] = (diff < window) && (TGT != '0);
         assign term[c] = {{(TERM_W-CHAN_W){1'b0}}, diff} * RECIP;
      end

      assign score     = SCORE_W'(term[0]) + SCORE_W'(term[1]) + SCORE_W'(term[2]);
      assign exact     = (in_color == PAL_COLORS[i]);
      assign qualified = (&chan_ok) && (score < SCORE_W'(SCORE_LIMIT));

      assign cand_in[i].valid = exact || qualified;
      assign cand_in[i].key   = exact ? '0 : score[KEY_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff <= cand_in;
   end

endmodule

`default_nettype wire

// File: src/npcm_select.sv
// ----------------------------------------------------------------------------
// npcm_select
// Picks the lowest key among the candidate words through a comparison tree,
// the lower index winning a tie, and registers the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module npcm_select #(
   parameter int PALETTE_ENTRIES = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire npcm_pkg::cand_type  cand [PALETTE_ENTRIES],
   output logic                     rsp_valid_ff,
   output npcm_pkg::index_type      rsp_index_ff,
   output npcm_pkg::color_type      rsp_color_ff
);
   import npcm_pkg::*;

   cand_type  leaf [PAL_MAX];
   cand_type  node [2*PAL_MAX];
   index_type node_idx [2*PAL_MAX];
   index_type best_idx;

   for (genvar n = 0; n < PAL_MAX; n++) begin : g_leaf
      if (n < PALETTE_ENTRIES) begin : g_used
         assign leaf[n] = cand[n];
      end else begin : g_unused
         assign leaf[n] = '0;
      end
   end

   always_comb begin
      node[0]     = '0;
      node_idx[0] = '0;
      for (int n = 0; n < PAL_MAX; n++) begin
         node[PAL_MAX+n]     = leaf[n];
         node_idx[PAL_MAX+n] = INDEX_W'(n);
      end
      for (int n = PAL_MAX - 1; n >= 1; n--) begin
         if (node[2*n+1].valid && (!node[2*n].valid || node[2*n+1].key < node[2*n].key)) begin
            node[n]     = node[2*n+1];
            node_idx[n] = node_idx[2*n+1];
         end else begin
            node[n]     = node[2*n];
            node_idx[n] = node_idx[2*n];
         end
      end
   end

   assign best_idx = node[1].valid ? node_idx[1] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_index_ff <= best_idx;
      rsp_color_ff <= PAL_COLORS[best_idx];
   end

endmodule

`default_nettype wire

// File: src/nearest_palette_color_match.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_match
// Matches a 24-bit color against a fixed palette and returns the index and
// value of the exact or nearest qualifying entry.
//
//   Channel   Ports                                   Handshake
//   request   req_source_color                        start, busy
//   response  rsp_color_index, rsp_matched_color      rsp_valid strobe
//   config    csr_write_data                          csr_write_enable
//
// A new word is taken in every cycle; busy is high only during reset.
// Each result passes through the input register, the score register and
// the result register after its request.
// Reset clears the pipeline valid bits and sets match_window to 25.
// The result is shown for one cycle only; the receiver cannot stall it.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_palette_color_match #(
   parameter int PALETTE_ENTRIES = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire npcm_pkg::color_type req_source_color,
   input  wire logic                csr_write_enable,
   input  wire npcm_pkg::chan_type  csr_write_data,
   output logic                     rsp_valid,
   output npcm_pkg::index_type      rsp_color_index,
   output npcm_pkg::color_type      rsp_matched_color
);
   import npcm_pkg::*;

   logic      req_valid_ff;
   color_type req_color_ff;
   chan_type  match_window_ff;
   logic      score_valid;
   cand_type  score_cand [PALETTE_ENTRIES];

   assign busy = reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff    <= 1'b0;
         match_window_ff <= WINDOW_RESET;
      end else begin
         req_valid_ff <= start && !busy;
         if (csr_write_enable) begin
            match_window_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_color_ff <= req_source_color;
   end

   npcm_score #(
      .PALETTE_ENTRIES(PALETTE_ENTRIES)
   ) u_score (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid_ff),
      .in_color    (req_color_ff),
      .window      (match_window_ff),
      .out_valid_ff(score_valid),
      .cand_ff     (score_cand)
   );

   npcm_select #(
      .PALETTE_ENTRIES(PALETTE_ENTRIES)
   ) u_select (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (score_valid),
      .cand        (score_cand),
      .rsp_valid_ff(rsp_valid),
      .rsp_index_ff(rsp_color_index),
      .rsp_color_ff(rsp_matched_color)
   );

endmodule

`default_nettype wire

// File: src/npcm_checker.sv
// ----------------------------------------------------------------------------
// npcm_checker
// Port-level checks of result timing, result index range, readiness and of fixed palette answers.
// ----------------------------------------------------------------------------
`default_nettype none

module npcm_checker #(
   parameter int PALETTE_ENTRIES = 16
) (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                start,
   input wire logic                busy,
   input wire npcm_pkg::color_type req_source_color,
   input wire logic                rsp_valid,
   input wire npcm_pkg::index_type rsp_color_index,
   input wire npcm_pkg::color_type rsp_matched_color
);
   import npcm_pkg::*;

   logic accept;

   assign accept = start && !busy;

   // Every result word comes from an earlier accepted request word.
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 3))
      else $error("result word without a matching request");

   // The chosen index lies within the active palette.
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_color_index) < PALETTE_ENTRIES))
      else $error("result index beyond the palette");

   // White is always an exact match at its own entry.
   a_white_exact: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_source_color, 3) == 24'hFFFFFF)
         |-> (rsp_color_index == 4'd1 && rsp_matched_color == 24'hFFFFFF))
      else $error("white not matched to its palette entry");

   // Outside reset the block is always ready for a new word.
   a_never_busy: assert property (@(posedge clock)
      !reset |-> !busy)
      else $error("busy raised outside reset");

endmodule

bind nearest_palette_color_match npcm_checker #(
   .PALETTE_ENTRIES(PALETTE_ENTRIES)
) u_npcm_checker (.*);

`default_nettype wire
